>>> hw/rtl/crsc_pkg.sv
// Shared constants, types and helper functions of the clock replacement sector cache.
`timescale 1ns / 1ps
`default_nettype none
package crsc_pkg;

  localparam int ENTRIES      = 64;
  localparam int MAX_RESULTS  = 64;
  localparam int IDX_W        = $clog2(ENTRIES);
  localparam int CNT_W        = $clog2(MAX_RESULTS);
  localparam int CMD_W        = 2;
  localparam int SECTOR_W     = 32;
  localparam int ENTRY_IDX_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_code_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_EMIT,
    S_FLUSH_PICK,
    S_FLUSH_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic lookup;
    logic decide;
    logic flush_pick;
    logic load_out;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;
    logic flush_none;
    logic flush_last;
  } dp_status_t;

  typedef struct packed {
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic                   hit;
    logic                   fill_needed;
    logic                   writeback_needed;
    logic [SECTOR_W-1:0]    writeback_sector;
    logic                   last_result;
  } result_t;

  // lowest set bit of the vector; zero when none is set
  function automatic logic [IDX_W-1:0] first_set(input logic [ENTRIES-1:0] v);
    logic [IDX_W-1:0] r;
    r = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (v[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/crsc_in_if.sv
// Input channel interface: command and sector with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface crsc_in_if;
  import crsc_pkg::*;

  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [SECTOR_W-1:0] sector;

  modport source (output valid, output cmd, output sector, input ready);
  modport sink   (input valid, input cmd, input sector, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/crsc_out_if.sv
// Result channel interface: entry, hit/fill/writeback flags and sector with valid/ready.
`timescale 1ns / 1ps
`default_nettype none
interface crsc_out_if;
  import crsc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [ENTRY_IDX_W-1:0] entry_index;
  logic                   hit;
  logic                   fill_needed;
  logic                   writeback_needed;
  logic [SECTOR_W-1:0]    writeback_sector;
  logic                   last_result;

  modport source (output valid, output entry_index, output hit, output fill_needed,
                  output writeback_needed, output writeback_sector, output last_result,
                  input ready);
  modport sink   (input valid, input entry_index, input hit, input fill_needed,
                  input writeback_needed, input writeback_sector, input last_result,
                  output ready);
endinterface
`default_nettype wire

>>> hw/rtl/crsc_ctrl.sv
// Controller state machine sequencing lookups, replacement and flush walks.
`timescale 1ns / 1ps
`default_nettype none
module crsc_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [crsc_pkg::CMD_W-1:0]    in_cmd,
  input  crsc_pkg::dp_status_t          stat_i,
  output logic                          in_ready,
  output crsc_pkg::ctrl_cmd_t           cmd_o
);
  import crsc_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_cmd == CMD_READ || in_cmd == CMD_WRITE) state_nxt = S_LOOKUP;
          else if (in_cmd == CMD_FLUSH)                 state_nxt = S_FLUSH_PICK;
          else                                          state_nxt = S_IDLE;
        end
      end
      S_LOOKUP:     state_nxt = S_DECIDE;
      S_DECIDE:     state_nxt = S_EMIT;
      S_EMIT: begin
        if (stat_i.slot_free) state_nxt = S_IDLE;
      end
      S_FLUSH_PICK: state_nxt = stat_i.flush_none ? S_IDLE : S_FLUSH_EMIT;
      S_FLUSH_EMIT: begin
        if (stat_i.slot_free) state_nxt = stat_i.flush_last ? S_IDLE : S_FLUSH_PICK;
      end
      default:      state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd_o    = '0;
    case (state_r)
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd_o.accept = in_valid;
      end
      S_LOOKUP:     cmd_o.lookup     = 1'b1;
      S_DECIDE:     cmd_o.decide     = 1'b1;
      S_EMIT:       cmd_o.load_out   = stat_i.slot_free;
      S_FLUSH_PICK: cmd_o.flush_pick = 1'b1;
      S_FLUSH_EMIT: cmd_o.load_out   = stat_i.slot_free;
      default: begin
        in_ready = 1'b0;
        cmd_o    = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/crsc_dpath.sv
// Datapath: tag compare, entry mark bits, clock hand, tag store and result register.
`timescale 1ns / 1ps
`default_nettype none
module crsc_dpath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crsc_pkg::ctrl_cmd_t           cmd_i,
  input  logic [crsc_pkg::CMD_W-1:0]    in_cmd,
  input  logic [crsc_pkg::SECTOR_W-1:0] in_sector,
  input  logic                          out_ready,
  output crsc_pkg::dp_status_t          stat_o,
  output logic                          out_valid,
  output crsc_pkg::result_t             res_o
);
  import crsc_pkg::*;

  // tag copy for the parallel compare, and tag store for the writeback read
  logic [SECTOR_W-1:0] tag_r   [ENTRIES];
  logic [SECTOR_W-1:0] tag_mem [ENTRIES];
  logic [SECTOR_W-1:0] rd_r;

  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [ENTRIES-1:0] ref_r, ref_nxt;
  logic [ENTRIES-1:0] dirty_r, dirty_nxt;
  logic [IDX_W-1:0]   hand_r, hand_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            res_r;

  logic [CMD_W-1:0]    cmd_r;
  logic [SECTOR_W-1:0] sec_r;
  logic [ENTRIES-1:0]  match_r, match_nxt;
  logic [IDX_W-1:0]    idx_r;
  logic                hit_r, fill_r, wb_r, last_r;
  logic [CNT_W-1:0]    cnt_r;

  logic               hit, empty, use_clock, is_write;
  logic [IDX_W-1:0]   hit_idx, empty_idx, vict, hand_wrap, sel_idx;
  logic [ENTRIES-1:0] nref, ge_vec, lt_vec, hi_vec, clear_vec, sel_oh;
  logic               hi_found, any_found;
  logic [ENTRIES-1:0] pending, fl_oh;
  logic [IDX_W-1:0]   fl_idx;
  logic               flush_none, fl_last;
  logic [IDX_W-1:0]   mem_addr;
  logic               mem_we;
  logic               mem_re;
  logic               slot_free;

  assign is_write = (cmd_r == CMD_WRITE);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_nxt[i] = valid_r[i] && (tag_r[i] == sec_r);
    end
  end

  // lookup / victim choice
  assign hit       = |match_r;
  assign hit_idx   = first_set(match_r);
  assign empty     = |(~valid_r);
  assign empty_idx = first_set(~valid_r);
  assign nref      = ~ref_r;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      ge_vec[i] = (IDX_W'(i) >= hand_r);
    end
  end

  assign hi_vec    = nref & ge_vec;
  assign hi_found  = |hi_vec;
  assign any_found = |nref;
  assign vict      = hi_found ? first_set(hi_vec) : (any_found ? first_set(nref) : hand_r);
  assign hand_wrap = (vict == IDX_W'(ENTRIES - 1)) ? '0 : vict + 1'b1;

  // reference marks the hand sweeps over on its way to the victim
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      lt_vec[i]    = (IDX_W'(i) < vict);
      clear_vec[i] = !any_found ||
                     (hi_found ? (ge_vec[i] && lt_vec[i]) : (ge_vec[i] || lt_vec[i]));
    end
  end

  assign use_clock = !hit && !empty;
  assign sel_idx   = hit ? hit_idx : (empty ? empty_idx : vict);
  assign sel_oh    = ENTRIES'(1) << sel_idx;

  // flush walk
  assign pending    = valid_r & dirty_r;
  assign fl_idx     = first_set(pending);
  assign fl_oh      = ENTRIES'(1) << fl_idx;
  assign flush_none = !(|pending);
  assign fl_last    = !(|(pending & ~fl_oh)) || (cnt_r == CNT_W'(MAX_RESULTS - 1));

  assign mem_addr = cmd_i.flush_pick ? fl_idx : sel_idx;
  assign mem_we   = cmd_i.decide && !hit;
  // read only when an entry is picked, so the sector holds while the result waits
  assign mem_re   = cmd_i.decide || cmd_i.flush_pick;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    ref_nxt   = ref_r;
    dirty_nxt = dirty_r;
    hand_nxt  = hand_r;
    if (cmd_i.decide) begin
      if (use_clock) begin
        ref_nxt  = ref_r & ~clear_vec;
        hand_nxt = hand_wrap;
      end
      ref_nxt = ref_nxt | sel_oh;
      if (!hit) begin
        valid_nxt = valid_r | sel_oh;
        dirty_nxt = dirty_r & ~sel_oh;
      end
      if (is_write) dirty_nxt = dirty_nxt | sel_oh;
    end else if (cmd_i.flush_pick && !flush_none) begin
      dirty_nxt = dirty_r & ~fl_oh;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_i.load_out)  out_valid_nxt = 1'b1;
    else if (out_ready)  out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      ref_r       <= '0;
      dirty_r     <= '0;
      hand_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      ref_r       <= ref_nxt;
      dirty_r     <= dirty_nxt;
      hand_r      <= hand_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // tag store, read-first
  always_ff @(posedge clk) begin
    if (mem_re) rd_r <= tag_mem[mem_addr];
    if (mem_we) tag_mem[mem_addr] <= sec_r;
  end

  always_ff @(posedge clk) begin
    if (mem_we) tag_r[sel_idx] <= sec_r;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.accept) begin
      cmd_r <= in_cmd;
      sec_r <= in_sector;
      cnt_r <= '0;
    end
    if (cmd_i.lookup) match_r <= match_nxt;
    if (cmd_i.decide) begin
      idx_r  <= sel_idx;
      hit_r  <= hit;
      fill_r <= !hit;
      wb_r   <= use_clock && dirty_r[vict];
      last_r <= 1'b1;
    end else if (cmd_i.flush_pick) begin
      idx_r  <= fl_idx;
      hit_r  <= 1'b0;
      fill_r <= 1'b0;
      wb_r   <= 1'b1;
      last_r <= fl_last;
      cnt_r  <= cnt_r + 1'b1;
    end
    if (cmd_i.load_out) begin
      res_r.entry_index      <= ENTRY_IDX_W'(idx_r);
      res_r.hit              <= hit_r;
      res_r.fill_needed      <= fill_r;
      res_r.writeback_needed <= wb_r;
      res_r.writeback_sector <= wb_r ? rd_r : '0;
      res_r.last_result      <= last_r;
    end
  end

  assign stat_o.slot_free  = slot_free;
  assign stat_o.flush_none = flush_none;
  assign stat_o.flush_last = last_r;
  assign out_valid         = out_valid_r;
  assign res_o             = res_r;

  a_decide_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.decide |=> valid_r[idx_r] && ref_r[idx_r])
    else $error("chosen entry not valid and referenced after decision");

  a_load_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.load_out |-> slot_free)
    else $error("result register overwritten while still held");

  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.hit |-> !res_r.fill_needed && !res_r.writeback_needed)
    else $error("hit result with fill or writeback");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.flush_pick && !flush_none |=> !dirty_r[idx_r])
    else $error("flushed entry still dirty");

endmodule
`default_nettype wire

>>> hw/rtl/clock_replacement_sector_cache.sv
// Top level of the second-chance clock replacement sector cache controller.
`timescale 1ns / 1ps
`default_nettype none
// Tag and replacement controller for a fully associative cache of disk sectors.
// Each read or write item is compared against every valid tag at once. A hit
// reuses its entry; a miss takes the lowest invalid entry, or once the cache is
// full, the victim picked by the clock hand, which clears the reference mark of
// every entry it passes and stops on the first unreferenced one (a dirty victim
// reports a writeback of its old sector). A flush item walks the valid dirty
// entries in ascending order, one result per entry, and cleans them; nothing
// dirty means no result. Command code 3 is dropped silently.
// Timing: an access steps through accept, tag compare, decide and update, and
// load result, where the load waits for a free output register; a new item is
// taken only once the result of the last one is loaded. A flush steps through
// a pick and a result load for each dirty entry after the accept. The output
// register lets the next item be accepted while a result still waits on
// out_ch.ready.
// No clearing pass is needed after reset: valid, reference and dirty marks are
// flip-flops that reset clears.
module clock_replacement_sector_cache (
  input  logic            clk,
  input  logic            rst_n,
  crsc_in_if.sink         in_ch,
  crsc_out_if.source      out_ch
);
  import crsc_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_stat;
  result_t    res;
  logic       res_valid;

  // sequencer: one item at a time
  crsc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .stat_i   (dp_stat),
    .in_ready (in_ch.ready),
    .cmd_o    (ctrl_cmd)
  );

  // tags, marks, clock hand and result register
  crsc_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_i     (ctrl_cmd),
    .in_cmd    (in_ch.cmd),
    .in_sector (in_ch.sector),
    .out_ready (out_ch.ready),
    .stat_o    (dp_stat),
    .out_valid (res_valid),
    .res_o     (res)
  );

  assign out_ch.valid            = res_valid;
  assign out_ch.entry_index      = res.entry_index;
  assign out_ch.hit              = res.hit;
  assign out_ch.fill_needed      = res.fill_needed;
  assign out_ch.writeback_needed = res.writeback_needed;
  assign out_ch.writeback_sector = res.writeback_sector;
  assign out_ch.last_result      = res.last_result;

endmodule
`default_nettype wire
